// File: rtl/pcf_pkg.sv
// shared constants and types of the pairwise contact finder
package pcf_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 24;
  localparam int CUTOFF_BITS    = 50;
  localparam int INDEX_BITS     = 6;
  localparam int OUT_DATA_W     = 16;

  typedef struct packed {
    logic hit;
    logic busy;
  } pipe_stat_t;

endpackage

// File: rtl/pcf_point_store.sv
// point store: one memory of packed x, y, z words, registered read
module pcf_point_store import pcf_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IdxW   = $clog2(MAX_POINTS),
  localparam int PointW = 3 * COORD_BITS
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IdxW-1:0]   wr_addr,
  input  logic [PointW-1:0] wr_point,
  input  logic              rd_en,
  input  logic [IdxW-1:0]   rd_addr,
  output logic [PointW-1:0] rd_point
);

  logic [PointW-1:0] mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_point;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_point <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/pcf_dist_pipe.sv
// squared distance pipeline: gap magnitudes, squares, sum, cutoff compare
module pcf_dist_pipe import pcf_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int IDX_W      = INDEX_BITS,
  localparam int PointW = 3 * COORD_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   issue_valid,
  input  logic [IDX_W-1:0]       issue_idx,
  input  logic [PointW-1:0]      stored_point,
  input  logic [PointW-1:0]      probe_point,
  input  logic [CUTOFF_BITS-1:0] cutoff,
  output pipe_stat_t             stat,
  output logic [IDX_W-1:0]       hit_idx
);

  localparam int SqW  = 2 * COORD_BITS;
  localparam int SumW = SqW + 2;
  localparam int CmpW = (SumW > CUTOFF_BITS) ? SumW : CUTOFF_BITS;

  logic                   v1, v2, v3, v4;
  logic [IDX_W-1:0]       idx1, idx2, idx3, idx4;
  logic signed [COORD_BITS:0] gap [3];
  logic [COORD_BITS-1:0]  mag_next [3];
  logic [COORD_BITS-1:0]  mag [3];
  logic [SqW-1:0]         sq [3];
  logic [SumW-1:0]        sum;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      gap[k] = $signed({probe_point[k*COORD_BITS + COORD_BITS - 1],
                        probe_point[k*COORD_BITS +: COORD_BITS]})
             - $signed({stored_point[k*COORD_BITS + COORD_BITS - 1],
                        stored_point[k*COORD_BITS +: COORD_BITS]});
      mag_next[k] = gap[k][COORD_BITS] ? COORD_BITS'(-gap[k]) : gap[k][COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= issue_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx1 <= issue_idx;
      idx2 <= idx1;
      idx3 <= idx2;
      idx4 <= idx3;
      for (int k = 0; k < 3; k++) begin
        mag[k] <= mag_next[k];
        sq[k]  <= SqW'(mag[k]) * SqW'(mag[k]);
      end
      sum <= SumW'(sq[0]) + SumW'(sq[1]) + SumW'(sq[2]);
    end
  end

  assign stat.hit  = v4 && (CmpW'(sum) < CmpW'(cutoff));
  assign stat.busy = v1 | v2 | v3 | v4;
  assign hit_idx   = idx4;

endmodule

// File: rtl/pairwise_contact_finder_unit.sv
// pairwise contact finder: point store, distance pipeline and scan control
//
// channel  dir  handshake                 payload
// s_*      in   s_tvalid / s_tready       tdata x, y, z; tuser new_group
// m_*      out  m_tvalid / m_tready       tdata earlier, newer; tlast; tuser overflow
// cfg_*    in   cfg_valid / cfg_ready     cutoff_squared
//
// a point with n stored predecessors is compared with each of them; one stored
// point leaves the memory read port each cycle unless the pipeline is held
// the first point of a group and an overflowed point need no scan
// rst clears the point count, cutoff and control; the store needs no clearing
// a blocked output holds the pipeline only when a second close pair meets a
// full output register
module pairwise_contact_finder_unit import pcf_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int InDataW = ((3 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [InDataW-1:0]     s_tdata,   // x_coord, y_coord, z_coord, zero fill
  input  logic                   s_tuser,   // new_group
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata,   // earlier_index, newer_index, zero fill
  output logic                   m_tlast,
  output logic                   m_tuser,   // overflow
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CUTOFF_BITS-1:0] cfg_data
);

  localparam int IdxW   = $clog2(MAX_POINTS);
  localparam int CntW   = $clog2(MAX_POINTS + 1);
  localparam int PointW = 3 * COORD_BITS;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_OVF   = 4'b1000
  } state_t;

  state_t                 state, state_next;
  logic [CntW-1:0]        point_count;
  logic [CntW-1:0]        grp_count;
  logic [CntW-1:0]        scan_n;
  logic [CntW-1:0]        issue_idx;
  logic [IdxW-1:0]        newer_idx;
  logic [PointW-1:0]      probe_point;
  logic [PointW-1:0]      stored_point;
  logic [CUTOFF_BITS-1:0] cutoff;
  logic                   pend_valid;
  logic [IdxW-1:0]        pend_idx;
  logic [IdxW-1:0]        hit_idx;
  pipe_stat_t             stat;
  logic                   accept, full, adv, out_free, issue_valid, scan_done;
  logic                   load_pair, load_last, load_ovf;
  logic [INDEX_BITS-1:0]  out_earlier, out_newer;
  logic                   out_last, out_ovf, out_valid;

  assign accept      = s_tvalid && s_tready;
  assign s_tready    = (state == ST_IDLE);
  assign grp_count   = s_tuser ? '0 : point_count;
  assign full        = (grp_count >= CntW'(MAX_POINTS));
  assign out_free    = !out_valid || m_tready;
  assign adv         = !(stat.hit && pend_valid && !out_free);
  assign issue_valid = (state == ST_SCAN) && (issue_idx < scan_n);
  assign scan_done   = (state == ST_SCAN) && (issue_idx == scan_n) && !stat.busy;
  assign load_pair   = adv && stat.hit && pend_valid;
  assign load_last   = (state == ST_FLUSH) && out_free;
  assign load_ovf    = (state == ST_OVF) && out_free;

  pcf_point_store #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_store (
    .clk      (clk),
    .wr_en    (accept && !full),
    .wr_addr  (grp_count[IdxW-1:0]),
    .wr_point (s_tdata[PointW-1:0]),
    .rd_en    (adv),
    .rd_addr  (issue_idx[IdxW-1:0]),
    .rd_point (stored_point)
  );

  pcf_dist_pipe #(
    .COORD_BITS(COORD_BITS),
    .IDX_W     (IdxW)
  ) u_pipe (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .issue_valid  (issue_valid),
    .issue_idx    (issue_idx[IdxW-1:0]),
    .stored_point (stored_point),
    .probe_point  (probe_point),
    .cutoff       (cutoff),
    .stat         (stat),
    .hit_idx      (hit_idx)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (full) begin
            state_next = ST_OVF;
          end else if (grp_count != '0) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = pend_valid ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_OVF: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      point_count <= '0;
      cutoff      <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
      issue_idx   <= '0;
      scan_n      <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        cutoff <= cfg_data;
      end
      if (accept && !full) begin
        point_count <= grp_count + CntW'(1);
        scan_n      <= grp_count;
        issue_idx   <= '0;
      end else if (adv && issue_valid) begin
        issue_idx <= issue_idx + CntW'(1);
      end
      if (adv && stat.hit) begin
        pend_valid <= 1'b1;
      end else if (load_last) begin
        pend_valid <= 1'b0;
      end
      if (load_pair || load_last || load_ovf) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      probe_point <= s_tdata[PointW-1:0];
      newer_idx   <= grp_count[IdxW-1:0];
    end
    if (adv && stat.hit) begin
      pend_idx <= hit_idx;
    end
    if (load_pair || load_last) begin
      out_earlier <= INDEX_BITS'(pend_idx);
      out_newer   <= INDEX_BITS'(newer_idx);
      out_last    <= load_last;
      out_ovf     <= 1'b0;
    end else if (load_ovf) begin
      out_earlier <= '0;
      out_newer   <= '0;
      out_last    <= 1'b1;
      out_ovf     <= 1'b1;
    end
  end

  assign m_tvalid  = out_valid;
  assign m_tdata   = {(OUT_DATA_W - 2 * INDEX_BITS)'(0), out_newer, out_earlier};
  assign m_tlast   = out_last;
  assign m_tuser   = out_ovf;
  assign cfg_ready = 1'b1;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CntW'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!pend_valid && !stat.busy))
    else $error("idle with work still in flight");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (issue_idx <= scan_n))
    else $error("scan index past stored points");

  a_ovf_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("overflow result not marked last");

endmodule
